### sv/assert_macros.svh
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every clock edge outside reset
`define HPST_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);
`endif

### sv/hpst_pkg.sv
// shared types and constants for the host power state tracker
// no dependencies
package hpst_pkg;
  localparam int unsigned ModeW = 2;
  localparam int unsigned CntW  = 24;
  localparam int unsigned PwrW  = 16;
  localparam int unsigned EnW   = 48;
  localparam int unsigned HostW = 6;

  localparam logic [ModeW-1:0] MODE_RUN   = 2'd0;
  localparam logic [ModeW-1:0] MODE_IDLE  = 2'd1;
  localparam logic [ModeW-1:0] MODE_SLEEP = 2'd2;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_ALLOC   = 3'd1;
  localparam logic [2:0] CMD_ALLOC_L = 3'd2;
  localparam logic [2:0] CMD_DEALLOC = 3'd3;
  localparam logic [2:0] CMD_SET_RUN = 3'd4;
  localparam logic [2:0] CMD_QUERY   = 3'd5;

  localparam logic [1:0] REG_RUN_PWR   = 2'd0;
  localparam logic [1:0] REG_IDLE_PWR  = 2'd1;
  localparam logic [1:0] REG_SLEEP_PWR = 2'd2;
  localparam logic [1:0] REG_MAX_IDLE  = 2'd3;

  localparam logic [CntW-1:0] CNT_MAX = '1;
  localparam logic [EnW-1:0]  EN_MAX  = '1;

  // one host's state
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [CntW-1:0]  cnt;
    logic             lock;
    logic             touched;
  } host_rec_t;

  // ring control broadcast to every cell
  typedef struct packed {
    logic shift;   // rotate the ring by one
    logic wr;      // replace head cell content
  } ring_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_TICK = 5'b00100,
    ST_OUT  = 5'b01000,
    ST_HOST = 5'b10000
  } state_t;
endpackage

### sv/hpst_cell.sv
// one storage cell of the host ring
// depends on hpst_pkg
module hpst_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  hpst_pkg::ring_ctl_t ctl,
  input  logic               is_head,
  input  hpst_pkg::host_rec_t head_wr,
  input  hpst_pkg::host_rec_t from_prev,
  output hpst_pkg::host_rec_t rec
);
  import hpst_pkg::*;
  host_rec_t rec_r, rec_nxt;

  always_comb begin
    rec_nxt = rec_r;
    if (ctl.shift) begin
      rec_nxt = from_prev;
    end else if (ctl.wr && is_head) begin
      rec_nxt = head_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '{mode: MODE_IDLE, cnt: '0, lock: 1'b0, touched: 1'b0};
    end else begin
      rec_r <= rec_nxt;
    end
  end

  assign rec = rec_r;
endmodule

### sv/hpst_ring.sv
// ring of host cells, rotates so the head cell is the one being processed
// depends on hpst_pkg, hpst_cell
module hpst_ring #(
  parameter int unsigned N = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hpst_pkg::ring_ctl_t ctl,
  input  hpst_pkg::host_rec_t head_wr,
  output hpst_pkg::host_rec_t head
);
  import hpst_pkg::*;
  host_rec_t recs [N];

  // cell 0 is the head; shifting moves cell i+1 into cell i, head (updated) to the tail
  for (genvar i = 0; i < N; i++) begin : g_cell
    host_rec_t prev_in;
    if (i == N - 1) begin : g_tail
      assign prev_in = head_wr;
    end else begin : g_mid
      assign prev_in = recs[i+1];
    end
    hpst_cell u_cell (
      .clk, .rst_n, .ctl,
      .is_head  (i == 0),
      .head_wr,
      .from_prev(prev_in),
      .rec      (recs[i])
    );
  end

  assign head = recs[0];
endmodule

### sv/host_power_state_tracker_unit.sv
// Host power state tracker. Per-host state lives in a ring of NUM_HOSTS cells that
// rotates one place per cycle; the head cell is the only one read or written.
// A tick makes two rotations: a first rotation only finds the last host that
// will fall asleep, a second updates each visited host and the three saturating
// energy totals and emits one transfer per host put to sleep; a tick with no
// sleeper adds a single result after its rotations. The rotation stalls while a
// slept result waits on out_tready. A host command rotates the ring once, changing
// the addressed host on the way, then emits its result. Output is a register;
// an item is taken only when the previous one is fully delivered.
// depends on hpst_pkg, hpst_ring
module host_power_state_tracker_unit #(
  parameter int unsigned NUM_HOSTS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // cmd[2:0], host[8:3], zero pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // host_mode, host_is_locked, slept_valid,
                                    // slept_host, error, run, idle, sleep energy
  output logic         out_tlast
);
  import hpst_pkg::*;
  localparam int unsigned IW = $clog2(NUM_HOSTS);
  localparam int unsigned CW = $clog2(2 * NUM_HOSTS + 1);

  logic [PwrW-1:0] run_pwr_r, idle_pwr_r, sleep_pwr_r;
  logic [CntW-1:0] max_idle_r;
  logic [EnW-1:0]  run_e_r, idle_e_r, sleep_e_r, run_e_nxt, idle_e_nxt, sleep_e_nxt;
  state_t          st_r, st_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;     // ring rotation steps so far
  logic [2:0]      cmd_r;
  logic [HostW-1:0] host_r;
  logic            err_r, err_nxt;
  logic            any_r, any_nxt;     // some host sleeps this tick
  logic [HostW-1:0] lidx_r, lidx_nxt;  // last host that sleeps this tick
  logic            ov_r, ov_nxt;
  logic [ModeW-1:0] om_r, om_nxt;
  logic            ol_r, ol_nxt, osv_r, osv_nxt, olast_r, olast_nxt, oerr_r, oerr_nxt;
  logic [HostW-1:0] osh_r, osh_nxt;
  ring_ctl_t       ctl;
  host_rec_t       head, head_wr;

  hpst_ring #(.N(NUM_HOSTS)) u_ring (.clk, .rst_n, .ctl, .head_wr, .head);

  assign cfg_ready = 1'b1;
  assign in_tready = (st_r == ST_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {5'b0, sleep_e_r, idle_e_r, run_e_r, oerr_r, osh_r, osv_r, ol_r, om_r};

  function automatic logic [EnW-1:0] sat(input logic [EnW-1:0] a, input logic [PwrW-1:0] b);
    logic [EnW:0] s;
    s = {1'b0, a} + {{(EnW-PwrW+1){1'b0}}, b};
    return s[EnW] ? EN_MAX : s[EnW-1:0];
  endfunction

  always_comb begin
    host_rec_t       r;
    logic            out_free;
    logic [CntW-1:0] cnt_inc;
    logic            visit;
    st_nxt = st_r; pos_nxt = pos_r; err_nxt = err_r; any_nxt = any_r; lidx_nxt = lidx_r;
    run_e_nxt = run_e_r; idle_e_nxt = idle_e_r; sleep_e_nxt = sleep_e_r;
    ov_nxt = ov_r; om_nxt = om_r; ol_nxt = ol_r; osv_nxt = osv_r; osh_nxt = osh_r;
    olast_nxt = olast_r; oerr_nxt = oerr_r;
    ctl = '0;
    r = head;
    out_free = !ov_r || out_tready;
    // saturating age and visit rule of the head host
    cnt_inc = (head.cnt != CNT_MAX) ? head.cnt + 1'b1 : head.cnt;
    visit = !head.touched || head.lock;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          pos_nxt = '0; any_nxt = 1'b0; err_nxt = 1'b0;
          st_nxt = (in_tdata[2:0] == CMD_TICK) ? ST_SCAN : ST_HOST;
        end
      end
      ST_SCAN: begin
        // read-only rotation: find the last host that will fall asleep
        if (visit && head.mode == MODE_IDLE && cnt_inc >= max_idle_r) begin
          any_nxt = 1'b1;
          lidx_nxt = HostW'(pos_r);
        end
        ctl.shift = 1'b1;
        pos_nxt = pos_r + 1'b1;
        if (pos_r == CW'(NUM_HOSTS - 1)) begin
          pos_nxt = '0;
          st_nxt = ST_TICK;
        end
      end
      ST_TICK: begin
        // hold while a slept result still occupies the output
        if (out_free) begin
          r.touched = 1'b0;
          if (visit) begin
            r.cnt = cnt_inc;
            case (head.mode)
              MODE_RUN:   run_e_nxt = sat(run_e_r, run_pwr_r);
              MODE_IDLE:  idle_e_nxt = sat(idle_e_r, idle_pwr_r);
              MODE_SLEEP: sleep_e_nxt = sat(sleep_e_r, sleep_pwr_r);
              default: ;
            endcase
            if (head.mode == MODE_IDLE && r.cnt >= max_idle_r) begin
              r.mode = MODE_SLEEP; r.cnt = '0;
              ov_nxt = 1'b1; om_nxt = '0; ol_nxt = 1'b0; osv_nxt = 1'b1;
              osh_nxt = HostW'(pos_r); oerr_nxt = 1'b0;
              olast_nxt = (HostW'(pos_r) == lidx_r);
            end
          end
          ctl.shift = 1'b1;
          pos_nxt = pos_r + 1'b1;
          if (pos_r == CW'(NUM_HOSTS - 1)) begin
            st_nxt = any_r ? ST_IDLE : ST_OUT;
          end
        end
      end
      ST_OUT: begin
        // no host slept: one plain result closes the tick
        if (out_free) begin
          ov_nxt = 1'b1; om_nxt = '0; ol_nxt = 1'b0; osv_nxt = 1'b0; osh_nxt = '0;
          olast_nxt = 1'b1; oerr_nxt = 1'b0; st_nxt = ST_IDLE;
        end
      end
      ST_HOST: begin
        if (32'(host_r) >= NUM_HOSTS) begin
          if (out_free) begin
            ov_nxt = 1'b1; om_nxt = '0; ol_nxt = 1'b0; osv_nxt = 1'b0; osh_nxt = '0;
            olast_nxt = 1'b1; oerr_nxt = 1'b1; st_nxt = ST_IDLE;
          end
        end else if (pos_r == CW'(NUM_HOSTS)) begin
          if (out_free) begin
            ov_nxt = 1'b1; osv_nxt = 1'b0; osh_nxt = '0; olast_nxt = 1'b1;
            oerr_nxt = err_r; st_nxt = ST_IDLE;
          end
        end else begin
          if (pos_r[IW-1:0] == host_r[IW-1:0] && pos_r < CW'(NUM_HOSTS)) begin
            case (cmd_r)
              CMD_ALLOC: begin
                if (head.mode == MODE_RUN) err_nxt = 1'b1;
                else begin r.mode = MODE_RUN; r.cnt = '0; r.touched = 1'b1; end
              end
              CMD_ALLOC_L: begin
                if (head.mode == MODE_RUN || head.lock) err_nxt = 1'b1;
                else begin r.lock = 1'b1; r.touched = 1'b1; end
              end
              CMD_DEALLOC: begin
                if (head.mode != MODE_RUN && !head.lock) err_nxt = 1'b1;
                else begin
                  r.mode = MODE_IDLE; r.cnt = '0; r.lock = 1'b0; r.touched = 1'b1;
                end
              end
              CMD_SET_RUN: begin
                if (head.mode == MODE_RUN) err_nxt = 1'b1;
                else begin r.mode = MODE_RUN; r.cnt = '0; end
              end
              CMD_QUERY: ;
              default: err_nxt = 1'b1;
            endcase
            om_nxt = r.mode; ol_nxt = r.lock;
          end
          ctl.shift = 1'b1;
          pos_nxt = pos_r + 1'b1;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    head_wr = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0; pos_r <= '0; err_r <= 1'b0; any_r <= 1'b0;
      lidx_r <= '0;
      run_e_r <= '0; idle_e_r <= '0; sleep_e_r <= '0;
      run_pwr_r <= 16'd100; idle_pwr_r <= 16'd51; sleep_pwr_r <= 16'd8;
      max_idle_r <= 24'd10;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; pos_r <= pos_nxt; err_r <= err_nxt; any_r <= any_nxt;
      lidx_r <= lidx_nxt;
      run_e_r <= run_e_nxt; idle_e_r <= idle_e_nxt; sleep_e_r <= sleep_e_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_RUN_PWR:   run_pwr_r <= cfg_data[PwrW-1:0];
          REG_IDLE_PWR:  idle_pwr_r <= cfg_data[PwrW-1:0];
          REG_SLEEP_PWR: sleep_pwr_r <= cfg_data[PwrW-1:0];
          REG_MAX_IDLE:  max_idle_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    om_r <= om_nxt; ol_r <= ol_nxt; osv_r <= osv_nxt; osh_r <= osh_nxt;
    olast_r <= olast_nxt; oerr_r <= oerr_nxt;
    if (in_tvalid && in_tready) begin
      cmd_r <= in_tdata[2:0]; host_r <= in_tdata[8:3];
    end
  end
endmodule

### sv/hpst_checker.sv
// port-level checks for the host power state tracker, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module hpst_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata,
  input logic         out_tlast
);
  `HPST_ASSERT(a_hold, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata), "payload changed while stalled")
  `HPST_ASSERT(a_no_in_while_out, clk, rst_n, out_tvalid |-> !in_tready, "input taken with result pending")
  `HPST_ASSERT(a_err_last, clk, rst_n, out_tvalid && out_tdata[10] |-> out_tlast, "error result not last")
  `HPST_ASSERT(a_slept_clean, clk, rst_n, out_tvalid && out_tdata[3] |-> !out_tdata[10] && out_tdata[2:0] == 3'b0, "slept result carries host fields")
endmodule

bind host_power_state_tracker_unit hpst_checker u_hpst_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);

### tb/host_power_state_tracker_unit_test.sv
// self-checking testbench for host_power_state_tracker_unit: directed and random
// host commands and ticks, checked against a behavioral scoreboard.
// depends on hpst_pkg and host_power_state_tracker_unit
`timescale 1ns / 100ps

module host_power_state_tracker_unit_test;
  import hpst_pkg::*;

  localparam int unsigned HOSTS = 64;
  localparam logic [2:0] CMD_BAD6 = 3'd6;  // unknown command codes
  localparam logic [2:0] CMD_BAD7 = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  // one expected result transfer
  typedef struct {
    logic [1:0]     mode;
    logic           locked;
    logic           slept_valid;
    logic [5:0]     slept_host;
    logic           last;
    logic           err;
    logic [EnW-1:0] run_e;
    logic [EnW-1:0] idle_e;
    logic [EnW-1:0] sleep_e;
  } power_result_t;

  // host table mirror and queue of results still to come
  class power_scoreboard;
    logic [1:0]      mode_tab[HOSTS];
    logic [CntW-1:0] age_tab[HOSTS];
    logic            lock_tab[HOSTS];
    logic            touch_tab[HOSTS];
    logic [EnW-1:0]  run_e, idle_e, sleep_e;
    logic [PwrW-1:0] pw_run, pw_idle, pw_sleep;
    logic [CntW-1:0] idle_limit;
    power_result_t   pending_q[$];
    int              errors;

    function new();
      for (int i = 0; i < HOSTS; i++) begin
        mode_tab[i] = MODE_IDLE;
        age_tab[i] = '0;
        lock_tab[i] = 1'b0;
        touch_tab[i] = 1'b0;
      end
      run_e = '0;
      idle_e = '0;
      sleep_e = '0;
      pw_run = 16'd100;
      pw_idle = 16'd51;
      pw_sleep = 16'd8;
      idle_limit = 24'd10;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        REG_RUN_PWR:   pw_run = val[PwrW-1:0];
        REG_IDLE_PWR:  pw_idle = val[PwrW-1:0];
        REG_SLEEP_PWR: pw_sleep = val[PwrW-1:0];
        REG_MAX_IDLE:  idle_limit = val;
        default: ;
      endcase
    endfunction

    function logic [EnW-1:0] sat_add(logic [EnW-1:0] a, logic [PwrW-1:0] b);
      logic [EnW:0] s;
      s = {1'b0, a} + {{(EnW-PwrW+1){1'b0}}, b};
      return s[EnW] ? EN_MAX : s[EnW-1:0];
    endfunction

    function power_result_t make(logic [1:0] m, logic lk, logic sv, logic [5:0] sh,
                                 logic lst, logic er);
      power_result_t r;
      r.mode = m;
      r.locked = lk;
      r.slept_valid = sv;
      r.slept_host = sh;
      r.last = lst;
      r.err = er;
      r.run_e = run_e;
      r.idle_e = idle_e;
      r.sleep_e = sleep_e;
      return r;
    endfunction

    // append one expected result at the tail
    function void queue_result(power_result_t r);
      pending_q.insert(pending_q.size(), r);
    endfunction

    // accepted input: update the mirror and queue its results
    function void note_input(logic [2:0] cmd, logic [5:0] h);
      logic er;
      int n;
      power_result_t r;
      er = 1'b0;
      n = 0;
      if (cmd == CMD_TICK) begin
        for (int i = 0; i < HOSTS; i++) begin
          if (touch_tab[i] && !lock_tab[i]) continue;
          if (age_tab[i] != CNT_MAX) age_tab[i]++;
          if (mode_tab[i] == MODE_RUN) run_e = sat_add(run_e, pw_run);
          else if (mode_tab[i] == MODE_IDLE) idle_e = sat_add(idle_e, pw_idle);
          else if (mode_tab[i] == MODE_SLEEP) sleep_e = sat_add(sleep_e, pw_sleep);
          if (mode_tab[i] == MODE_IDLE && age_tab[i] >= idle_limit) begin
            mode_tab[i] = MODE_SLEEP;
            age_tab[i] = '0;
            queue_result(make(2'd0, 1'b0, 1'b1, 6'(i), 1'b0, 1'b0));
            n++;
          end
        end
        for (int i = 0; i < HOSTS; i++) touch_tab[i] = 1'b0;
        if (n == 0) queue_result(make(2'd0, 1'b0, 1'b0, 6'd0, 1'b1, 1'b0));
        else pending_q[pending_q.size()-1].last = 1'b1;
        return;
      end
      case (cmd)
        CMD_ALLOC: begin
          if (mode_tab[h] == MODE_RUN) er = 1'b1;
          else begin
            mode_tab[h] = MODE_RUN;
            age_tab[h] = '0;
            touch_tab[h] = 1'b1;
          end
        end
        CMD_ALLOC_L: begin
          if (mode_tab[h] == MODE_RUN || lock_tab[h]) er = 1'b1;
          else begin
            lock_tab[h] = 1'b1;
            touch_tab[h] = 1'b1;
          end
        end
        CMD_DEALLOC: begin
          if (mode_tab[h] != MODE_RUN && !lock_tab[h]) er = 1'b1;
          else begin
            mode_tab[h] = MODE_IDLE;
            age_tab[h] = '0;
            lock_tab[h] = 1'b0;
            touch_tab[h] = 1'b1;
          end
        end
        CMD_SET_RUN: begin
          if (mode_tab[h] == MODE_RUN) er = 1'b1;
          else begin
            mode_tab[h] = MODE_RUN;
            age_tab[h] = '0;
          end
        end
        CMD_QUERY: ;
        default: er = 1'b1;
      endcase
      queue_result(make(mode_tab[h], lock_tab[h], 1'b0, 6'd0, 1'b1, er));
    endfunction

    task report(string what, logic [EnW-1:0] got, logic [EnW-1:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    // accepted result transfer: compare with the oldest expectation
    task check_result(logic [159:0] d, logic lst);
      power_result_t e;
      if (pending_q.size() == 0) begin
        report("unexpected transfer, tdata low bits", d[47:0], '0);
        return;
      end
      e = pending_q.pop_front();
      if (d[1:0] !== e.mode) report("host_mode", EnW'(d[1:0]), EnW'(e.mode));
      if (d[2] !== e.locked) report("host_is_locked", EnW'(d[2]), EnW'(e.locked));
      if (d[3] !== e.slept_valid) report("slept_valid", EnW'(d[3]), EnW'(e.slept_valid));
      if (d[9:4] !== e.slept_host) report("slept_host", EnW'(d[9:4]), EnW'(e.slept_host));
      if (d[10] !== e.err) report("error", EnW'(d[10]), EnW'(e.err));
      if (d[58:11] !== e.run_e) report("run_energy", d[58:11], e.run_e);
      if (d[106:59] !== e.idle_e) report("idle_energy", d[106:59], e.idle_e);
      if (d[154:107] !== e.sleep_e) report("sleep_energy", d[154:107], e.sleep_e);
      if (lst !== e.last) report("tlast", EnW'(lst), EnW'(e.last));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [15:0]  in_tdata = '0;   // cmd[2:0], host[8:3], zero pad
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [23:0]  cfg_data = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;       // mode, lock, slept_valid, slept_host, error, 3 energies
  logic         out_tlast;

  power_scoreboard sb = new();
  int unsigned cycles = 0;
  bit          gaps_on = 1'b1;   // cleared for back-to-back stretches
  int          ready_wait = 0;

  host_power_state_tracker_unit #(.NUM_HOSTS(HOSTS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("host_power_state_tracker_unit_test: FAIL");
      $finish;
    end
  end

  // receiver: hold ready low for a drawn number of cycles before each transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tlast);
      ready_wait = gaps_on ? $urandom_range(0, 7) : 0;
      out_tready <= (ready_wait == 0);
    end else if (ready_wait > 0) begin
      ready_wait--;
      out_tready <= (ready_wait == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // one input transfer; valid stays high across back-to-back items
  task send(logic [2:0] cmd, logic [5:0] h);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, h, cmd};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sb.note_input(cmd, h);
  endtask

  // let every expected transfer arrive, then settle
  task drain();
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // weighted mix, hosts mostly from a small set so commands interact
  task send_random(int count);
    int k;
    logic [2:0] c;
    logic [5:0] h;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      if (k < 25) c = CMD_TICK;
      else if (k < 45) c = CMD_ALLOC;
      else if (k < 57) c = CMD_ALLOC_L;
      else if (k < 75) c = CMD_DEALLOC;
      else if (k < 85) c = CMD_SET_RUN;
      else if (k < 95) c = CMD_QUERY;
      else c = (k[0]) ? CMD_BAD7 : CMD_BAD6;
      h = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
      if (n % 40 == 20) gaps_on = ~gaps_on;
      send(c, h);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every command, the error cases and both ends of the host field
    send(CMD_QUERY, 6'd0);
    send(CMD_ALLOC, 6'd0);
    send(CMD_ALLOC, 6'd0);        // already running
    send(CMD_ALLOC_L, 6'd0);      // lock on a running host
    send(CMD_DEALLOC, 6'd0);
    send(CMD_ALLOC_L, 6'd63);
    send(CMD_ALLOC_L, 6'd63);     // already locked
    send(CMD_TICK, 6'd63);        // locked host still visited
    send(CMD_DEALLOC, 6'd63);     // locked idle host released
    send(CMD_DEALLOC, 6'd42);     // neither running nor locked
    send(CMD_SET_RUN, 6'd21);
    send(CMD_SET_RUN, 6'd21);     // already running
    send(CMD_BAD6, 6'd1);
    send(CMD_BAD7, 6'd62);
    send(CMD_QUERY, 6'd21);
    for (int i = 0; i < 10; i++) send(CMD_TICK, 6'($urandom)); // idle hosts fall asleep
    send(CMD_QUERY, 6'd5);
    send_random(40);
    drain();  // sender holds off until every result is in

    // extremes of the registers, shortest idle limit
    write_reg(REG_RUN_PWR, 24'hFFFF);
    write_reg(REG_IDLE_PWR, 24'd0);
    write_reg(REG_SLEEP_PWR, 24'hFFFF);
    write_reg(REG_MAX_IDLE, 24'd1);
    send_random(50);
    drain();

    // opposite extremes, longest idle limit
    write_reg(REG_RUN_PWR, 24'd0);
    write_reg(REG_IDLE_PWR, 24'hFFFF);
    write_reg(REG_SLEEP_PWR, 24'd0);
    write_reg(REG_MAX_IDLE, 24'hFFFFFF);
    send_random(40);
    drain();

    // random powers, short idle limit for frequent sleep reports
    write_reg(REG_RUN_PWR, 24'($urandom));
    write_reg(REG_IDLE_PWR, 24'($urandom));
    write_reg(REG_SLEEP_PWR, 24'($urandom));
    write_reg(REG_MAX_IDLE, 24'($urandom_range(1, 4)));
    send_random(50);
    drain();

    if (sb.errors == 0) begin
      $display("host_power_state_tracker_unit_test: PASS");
    end else begin
      $display("host_power_state_tracker_unit_test: FAIL");
    end
    $finish;
  end
endmodule
